// File: design/cled_pkg.sv
// Shared types, codes and defaults for the counted LED blinker.
package cled_pkg;

  // Widths fixed by the register map and the stream fields.
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int CountW    = 15;
  localparam int PhaseW    = 16;
  localparam int LevelW    = 8;
  localparam int ModeW     = 2;
  localparam int InDataW   = 16;
  localparam int OutDataW  = 16;

  // Defaults for the top-level parameters.
  localparam int DefDurationBits = 16;
  localparam int DefMinPhaseMs   = 10;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] REG_ON_DUR  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OFF_DUR = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MODE    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ON_LVL  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OFF_LVL = 3'd4;

  // Blink modes.
  localparam logic [ModeW-1:0] MODE_OFF   = 2'd0;
  localparam logic [ModeW-1:0] MODE_ON    = 2'd1;
  localparam logic [ModeW-1:0] MODE_BLINK = 2'd2;
  localparam logic [ModeW-1:0] MODE_REV   = 2'd3;

  // Request kinds carried on tuser.
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // Register reset values.
  localparam logic [CfgDataW-1:0] RST_ON_DUR  = 16'd50;
  localparam logic [CfgDataW-1:0] RST_OFF_DUR = 16'd50;
  localparam logic [ModeW-1:0]    RST_MODE    = MODE_ON;
  localparam logic [LevelW-1:0]   RST_ON_LVL  = 8'd255;
  localparam logic [LevelW-1:0]   RST_OFF_LVL = 8'd0;

  typedef struct packed {
    logic [CfgDataW-1:0] on_duration_ms;
    logic [CfgDataW-1:0] off_duration_ms;
    logic [ModeW-1:0]    blink_mode;
    logic [LevelW-1:0]   on_level;
    logic [LevelW-1:0]   off_level;
  } cled_cfg_t;

endpackage

// File: design/cled_cfg_regs.sv
// Configuration register file of the counted LED blinker.
module cled_cfg_regs
  import cled_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output cled_cfg_t           cfg_o
);

  cled_cfg_t cfg_r;
  cled_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ON_DUR:  cfg_nxt.on_duration_ms  = cfg_wdata;
        REG_OFF_DUR: cfg_nxt.off_duration_ms = cfg_wdata;
        REG_MODE:    cfg_nxt.blink_mode      = cfg_wdata[ModeW-1:0];
        REG_ON_LVL:  cfg_nxt.on_level        = cfg_wdata[LevelW-1:0];
        REG_OFF_LVL: cfg_nxt.off_level       = cfg_wdata[LevelW-1:0];
        default: ;  // Indexes past the map are dropped.
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_duration_ms  <= RST_ON_DUR;
      cfg_r.off_duration_ms <= RST_OFF_DUR;
      cfg_r.blink_mode      <= RST_MODE;
      cfg_r.on_level        <= RST_ON_LVL;
      cfg_r.off_level       <= RST_OFF_LVL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// File: design/cled_step.sv
// Next-state and result logic for one tick or start request.
module cled_step
  import cled_pkg::*;
#(
  parameter int DURATION_BITS = DefDurationBits,
  parameter int MIN_PHASE_MS  = DefMinPhaseMs
)(
  input  cled_cfg_t                 cfg,
  input  logic                      req_type,
  input  logic [CountW-1:0]         blink_count,
  input  logic [PhaseW-1:0]         phase_count,
  input  logic [DURATION_BITS-1:0]  time_left,
  input  logic                      timer_armed,
  input  logic [LevelW-1:0]         level_now,
  output logic [PhaseW-1:0]         phase_count_nxt,
  output logic [DURATION_BITS-1:0]  time_left_nxt,
  output logic                      timer_armed_nxt,
  output logic [LevelW-1:0]         level_now_nxt
);

  // Wide enough for both a raw duration and the full timer range.
  localparam int ExtW = (DURATION_BITS > CfgDataW) ? DURATION_BITS : CfgDataW;
  localparam logic [ExtW-1:0] TimeMask = ExtW'({DURATION_BITS{1'b1}});
  localparam logic [ExtW-1:0] MinPhase = ExtW'(MIN_PHASE_MS);
  localparam logic [DURATION_BITS-1:0] TimeOne = DURATION_BITS'(1);

  logic [PhaseW-1:0]   start_count;
  logic                odd;
  logic                go_on;
  logic [CfgDataW-1:0] delay;
  logic [ExtW-1:0]     delay_ext;
  logic [ExtW-1:0]     delay_lo;
  logic [ExtW-1:0]     delay_cl;

  // 2N-1 phases for N pulses, none for N of zero.
  always_comb begin
    start_count = {blink_count, 1'b0};
    if (start_count != '0) begin
      start_count = start_count - PhaseW'(1);
    end
  end

  assign odd = phase_count[0];

  always_comb begin
    unique case (cfg.blink_mode)
      MODE_BLINK: go_on = odd;
      MODE_REV:   go_on = !odd;
      default:    go_on = 1'b0;
    endcase
  end

  assign delay     = go_on ? cfg.on_duration_ms : cfg.off_duration_ms;
  assign delay_ext = ExtW'(delay);
  assign delay_lo  = (delay_ext < MinPhase) ? MinPhase : delay_ext;
  assign delay_cl  = (delay_lo > TimeMask) ? TimeMask : delay_lo;

  always_comb begin
    phase_count_nxt = phase_count;
    time_left_nxt   = time_left;
    timer_armed_nxt = timer_armed;
    level_now_nxt   = level_now;
    if (req_type == REQ_START) begin
      phase_count_nxt = start_count;
      time_left_nxt   = TimeOne;
      timer_armed_nxt = 1'b1;
    end else if (timer_armed) begin
      if (time_left <= TimeOne) begin
        // The timer fires on this tick.
        time_left_nxt   = '0;
        timer_armed_nxt = 1'b0;
        unique case (cfg.blink_mode)
          MODE_OFF: level_now_nxt = cfg.off_level;
          MODE_ON:  level_now_nxt = cfg.on_level;
          MODE_BLINK, MODE_REV: begin
            level_now_nxt = go_on ? cfg.on_level : cfg.off_level;
            if (phase_count != '0) begin
              time_left_nxt   = delay_cl[DURATION_BITS-1:0];
              timer_armed_nxt = 1'b1;
              phase_count_nxt = phase_count - PhaseW'(1);
            end
          end
          default: ;
        endcase
      end else begin
        time_left_nxt = time_left - TimeOne;
      end
    end
  end

endmodule

// File: design/counted_led_blinker_unit.sv
// Top level of the counted LED blinker: input stage, state, result stage.
//
//  Channel  Direction  Beat contents
//  in_      slave      tuser: req_type (0 tick, 1 start); tdata: blink_count
//  out_     master     tdata: brightness, busy_res
//  cfg_     write      cfg_index selects a register, cfg_wdata is its value
//
// Every beat yields exactly one result beat. A beat is captured in the input
// register, and on the cycle it moves on the blinker state and the result
// register are updated together. The state update (tick countdown, phase
// step) is combinational, so one beat per clock is sustained while out_tready
// is high. A beat passes through the input register and then the result
// register before out_tvalid rises; a stalled output can hold it in the input register.
// Reset (synchronous, rst_n low) loads the register defaults and arms the
// timer to fire on the first tick. A stalled output holds its beat while
// the input register still takes one more beat; then in_tready drops.
module counted_led_blinker_unit
  import cled_pkg::*;
#(
  parameter int DURATION_BITS = DefDurationBits,
  parameter int MIN_PHASE_MS  = DefMinPhaseMs
)(
  input  logic                clk,
  input  logic                rst_n,
  // Input stream.
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // [14:0] blink_count, [15] zero
  input  logic                in_tuser,   // [0] req_type
  // Result stream.
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // [7:0] brightness, [8] busy_res, rest zero
  // Configuration writes.
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cled_cfg_t cfg;

  cled_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // Input register.
  logic              s1_valid_r;
  logic              s1_req_r;
  logic [CountW-1:0] s1_count_r;

  // Blinker state.
  logic [PhaseW-1:0]        phase_count_r;
  logic [PhaseW-1:0]        phase_count_nxt;
  logic [DURATION_BITS-1:0] time_left_r;
  logic [DURATION_BITS-1:0] time_left_nxt;
  logic                     timer_armed_r;
  logic                     timer_armed_nxt;
  logic [LevelW-1:0]        level_now_r;
  logic [LevelW-1:0]        level_now_nxt;

  // Result register.
  logic              out_valid_r;
  logic [LevelW-1:0] out_level_r;
  logic              out_busy_r;

  logic advance;
  logic in_fire;

  // The item in the input register moves on when the result slot is free.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  cled_step #(
    .DURATION_BITS (DURATION_BITS),
    .MIN_PHASE_MS  (MIN_PHASE_MS)
  ) u_step (
    .cfg             (cfg),
    .req_type        (s1_req_r),
    .blink_count     (s1_count_r),
    .phase_count     (phase_count_r),
    .time_left       (time_left_r),
    .timer_armed     (timer_armed_r),
    .level_now       (level_now_r),
    .phase_count_nxt (phase_count_nxt),
    .time_left_nxt   (time_left_nxt),
    .timer_armed_nxt (timer_armed_nxt),
    .level_now_nxt   (level_now_nxt)
  );

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      phase_count_r <= '0;
      time_left_r   <= DURATION_BITS'(1);
      timer_armed_r <= 1'b1;
      level_now_r   <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r   <= 1'b1;
        phase_count_r <= phase_count_nxt;
        time_left_r   <= time_left_nxt;
        timer_armed_r <= timer_armed_nxt;
        level_now_r   <= level_now_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r   <= in_tuser;
      s1_count_r <= in_tdata[CountW-1:0];
    end
    if (advance) begin
      out_level_r <= level_now_nxt;
      out_busy_r  <= timer_armed_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW - LevelW - 1){1'b0}}, out_busy_r, out_level_r};

  // A held result always mirrors the state it was taken from.
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_level_r == level_now_r) && (out_busy_r == timer_armed_r))
    else $error("result beat does not match blinker state");

  // A start request always arms the timer for the very next tick.
  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (s1_req_r == REQ_START)) |=>
      timer_armed_r && (time_left_r == DURATION_BITS'(1)))
    else $error("start request did not arm the timer");

  // A tick with the timer disarmed leaves the state alone.
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (s1_req_r == REQ_TICK) && !timer_armed_r) |=>
      $stable(phase_count_r) && $stable(time_left_r) && $stable(level_now_r)
      && !timer_armed_r)
    else $error("tick changed state while the timer was disarmed");

endmodule

// File: sim/counted_led_blinker_unit_tb.sv
// Self-checking testbench for the counted LED blinker stream unit.
`timescale 1ns / 100ps

module counted_led_blinker_unit_tb;
  import cled_pkg::*;

  // The run is cut off here if the result stream stops making progress.
  localparam int CycleLimit = 200000;

  // One result beat as the tracker expects it.
  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              busy;
  } led_out_t;

  // Tracks the blinker state beat by beat and holds the results still owed by the block.
  // The copy assumes the default instance parameters, so the countdown is
  // DefDurationBits wide, matching the duration registers. Saturation to the
  // countdown range therefore never applies.
  class led_level_tracker;
    cled_cfg_t                  regs;
    logic [PhaseW-1:0]          phases_left;
    logic [DefDurationBits-1:0] ms_left;
    bit                         armed;
    logic [LevelW-1:0]          level;
    led_out_t                   levels_due[$];
    int                         mismatches;

    function new();
      regs.on_duration_ms  = RST_ON_DUR;
      regs.off_duration_ms = RST_OFF_DUR;
      regs.blink_mode      = RST_MODE;
      regs.on_level        = RST_ON_LVL;
      regs.off_level       = RST_OFF_LVL;
      phases_left = '0;
      ms_left     = DefDurationBits'(1);
      armed       = 1'b1;
      level       = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_ON_DUR:  regs.on_duration_ms  = val;
        REG_OFF_DUR: regs.off_duration_ms = val;
        REG_MODE:    regs.blink_mode      = val[ModeW-1:0];
        REG_ON_LVL:  regs.on_level        = val[LevelW-1:0];
        REG_OFF_LVL: regs.off_level       = val[LevelW-1:0];
        default: ;
      endcase
    endfunction

    // Timer expiry: set the level, and in the blink modes step to the next phase.
    function void fire();
      bit                  go_on;
      logic [CfgDataW-1:0] delay;
      armed = 1'b0;
      case (regs.blink_mode)
        MODE_OFF: level = regs.off_level;
        MODE_ON:  level = regs.on_level;
        default: begin
          go_on = (regs.blink_mode == MODE_BLINK) ? phases_left[0] : !phases_left[0];
          if (go_on) begin
            level = regs.on_level;
            delay = regs.on_duration_ms;
          end else begin
            level = regs.off_level;
            delay = regs.off_duration_ms;
          end
          if (phases_left != 0) begin
            // Phases shorter than the minimum are stretched to it.
            ms_left     = (delay < CfgDataW'(DefMinPhaseMs)) ? CfgDataW'(DefMinPhaseMs) : delay;
            armed       = 1'b1;
            phases_left = phases_left - 1'b1;
          end
        end
      endcase
    endfunction

    function void take_beat(logic req, logic [CountW-1:0] n);
      logic [PhaseW-1:0] c;
      if (req == REQ_START) begin
        // N pulses take 2N-1 phase steps, the first one at the first fire.
        c = {n, 1'b0};
        if (c != 0) c = c - 1'b1;
        phases_left = c;
        ms_left     = DefDurationBits'(1);
        armed       = 1'b1;
      end else if (armed) begin
        if (ms_left <= 1) begin
          ms_left = '0;
          fire();
        end else begin
          ms_left = ms_left - 1'b1;
        end
      end
      levels_due.push_back('{level: level, busy: armed});
    endfunction

    task note_mismatch(string what);
      mismatches++;
      $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task match_level(logic [LevelW-1:0] lvl, logic busy);
      led_out_t want;
      if (levels_due.size() == 0) begin
        note_mismatch($sformatf("result beat level=%0d busy=%0b with nothing expected",
                                lvl, busy));
        return;
      end
      want = levels_due.pop_front();
      if (lvl !== want.level)
        note_mismatch($sformatf("brightness %0d, expected %0d", lvl, want.level));
      if (busy !== want.busy)
        note_mismatch($sformatf("busy %0b, expected %0b", busy, want.busy));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  led_level_tracker tracker = new();
  int               burst_left = 0;
  int               ready_hold = 0;
  int               cycle_count = 0;

  counted_led_blinker_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a stuck handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("counted_led_blinker_unit_tb: FAIL");
      $finish;
    end
  end

  // Every result beat is compared against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.match_level(out_tdata[LevelW-1:0], out_tdata[LevelW]);
  end

  // The receiver alternates between ready stretches and short stalls. Now and
  // then a ready stretch runs long, so the block also sees backpressure-free
  // windows. Each negedge makes at most one assignment to out_tready.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (ready_hold == 0) begin
      out_tready <= !out_tready;
      if (out_tready)
        ready_hold = $urandom_range(4, 0);
      else
        ready_hold = ($urandom_range(5) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 0);
    end else begin
      ready_hold--;
    end
  end

  // Present one beat and hold it until the block takes it. The sender works in
  // bursts; between bursts tvalid drops for a random number of cycles, and some
  // bursts follow each other with no gap at all.
  task automatic send_beat(input logic req, input logic [CountW-1:0] n);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {{(InDataW - CountW){1'b0}}, n};
    do @(posedge clk); while (!in_tready);
    tracker.take_beat(req, n);
    burst_left--;
  endtask

  // Ticks carry a random count field; the block must ignore it.
  task automatic send_ticks(input int k);
    repeat (k) send_beat(REQ_TICK, CountW'($urandom));
  endtask

  // Stop sending and let every owed result drain, then allow a margin before
  // the block counts as idle.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    tracker.write_reg(idx, val);
  endtask

  // Load a full register setting. Mode and levels go out with junk in the
  // unused upper bits, and one write to an unmapped index must be ignored.
  task automatic program_regs(input logic [CfgDataW-1:0] on_ms, input logic [CfgDataW-1:0] off_ms,
                              input logic [ModeW-1:0] mode, input logic [LevelW-1:0] on_lvl,
                              input logic [LevelW-1:0] off_lvl);
    logic [CfgDataW-1:0] junk;
    junk = $urandom;
    cfg_write(REG_ON_DUR, on_ms);
    cfg_write(REG_OFF_DUR, off_ms);
    cfg_write(REG_MODE, {junk[CfgDataW-1:ModeW], mode});
    cfg_write(REG_ON_LVL, {junk[CfgDataW-1:LevelW], on_lvl});
    cfg_write(REG_OFF_LVL, {junk[LevelW-1:0], off_lvl});
    cfg_write(CfgIdxW'($urandom_range(2 ** CfgIdxW - 1, REG_OFF_LVL + 1)), CfgDataW'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic. Most of it is a start followed by a run of ticks, often long
  // enough to walk through several blink phases; the rest is stray ticks and
  // starts with a full-range count that cut into a running sequence.
  task automatic random_traffic(input int n_items);
    int               sent;
    int               pick;
    int               k;
    logic [CountW-1:0] n;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        n = ($urandom_range(9) == 0) ? CountW'($urandom) : CountW'($urandom_range(4));
        if ($urandom_range(30) == 0) n = '1;
        send_beat(REQ_START, n);
        k = $urandom_range(60, 5);
        send_ticks(k);
        sent += k + 1;
      end else if (pick < 90) begin
        send_ticks(1);
        sent++;
      end else begin
        send_beat(REQ_START, CountW'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    logic [ModeW-1:0] mode;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = REQ_TICK;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_ON_DUR;
    cfg_wdata  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults (on mode): the armed timer fires on the first tick, a
    // second tick finds it disarmed, and starts in on mode just set the level.
    send_ticks(2);
    send_beat(REQ_START, '0);
    send_ticks(2);
    send_beat(REQ_START, CountW'(1));
    send_beat(REQ_TICK, '1);
    send_ticks(2);
    drain();

    // Blink with zero and just-too-short durations, both stretched to the
    // minimum phase: one pulse runs on, then off, then the timer stays idle.
    // A zero count fires once at the off level; the largest count keeps going.
    program_regs('0, CfgDataW'(DefMinPhaseMs - 1), MODE_BLINK, 8'hA5, 8'h5A);
    send_beat(REQ_START, CountW'(1));
    send_ticks(12);
    send_beat(REQ_START, '0);
    send_ticks(1);
    send_beat(REQ_START, '1);
    send_ticks(2);
    drain();

    for (int p = 0; p < 10; p++) begin
      case (p)
        // Reverse blink right at and just above the minimum, extreme levels.
        0: program_regs(CfgDataW'(DefMinPhaseMs), CfgDataW'(DefMinPhaseMs + 1), MODE_REV,
                        '1, '0);
        1: program_regs(CfgDataW'($urandom_range(25)), CfgDataW'($urandom_range(25)), MODE_OFF,
                        LevelW'($urandom), LevelW'($urandom));
        2: program_regs(CfgDataW'($urandom_range(25)), CfgDataW'($urandom_range(25)), MODE_ON,
                        LevelW'($urandom), LevelW'($urandom));
        // Longest on phase: only its start is reached, the timer stays busy.
        3: program_regs('1, CfgDataW'(1), MODE_BLINK, '0, '1);
        4: program_regs('0, '1, MODE_REV, LevelW'($urandom), LevelW'($urandom));
        default: begin
          mode = ModeW'($urandom);
          program_regs(CfgDataW'($urandom_range(25)), CfgDataW'($urandom_range(25)), mode,
                       LevelW'($urandom), LevelW'($urandom));
        end
      endcase
      random_traffic((p == 3 || p == 4) ? 30 : 65);
      drain();
    end

    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.levels_due.size() == 0)
      $display("counted_led_blinker_unit_tb: PASS");
    else
      $display("counted_led_blinker_unit_tb: FAIL");
    $finish;
  end

endmodule
